// ----- hdl/kmpd_pkg.sv -----
// Shared types, constants and character table for the key matrix press decoder.
package kmpd_pkg;

    localparam int NUM_ROWS    = 8;
    localparam int NUM_COLS    = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int CODE_W      = 8;
    localparam int NUM_ARROWS  = 4;
    localparam int TABLE_DEPTH = 56;
    localparam int CFG_INDEX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ARROW_UP    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ARROW_DOWN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ARROW_LEFT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ARROW_RIGHT = 3'd3;

    // Positions inside the arrow code array
    localparam int ARROW_UP    = 0;
    localparam int ARROW_DOWN  = 1;
    localparam int ARROW_LEFT  = 2;
    localparam int ARROW_RIGHT = 3;

    localparam logic [CODE_W-1:0] ARROW_UP_RESET    = 8'd91;
    localparam logic [CODE_W-1:0] ARROW_DOWN_RESET  = 8'd10;
    localparam logic [CODE_W-1:0] ARROW_LEFT_RESET  = 8'd8;
    localparam logic [CODE_W-1:0] ARROW_RIGHT_RESET = 8'd9;

    // Shift and control row: never yields a character
    localparam logic [ROW_W-1:0] ROW_MODIFIER = 3'd7;

    typedef logic [NUM_ARROWS-1:0][CODE_W-1:0] arrow_codes_t;
    typedef logic [NUM_COLS-1:0]               row_bits_t;

    typedef struct packed {
        logic             changed;
        logic             pressed;
        logic [COL_W-1:0] column;
    } lane_res_t;

    typedef struct packed {
        logic              hit;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic              hold;
        logic [CODE_W-1:0] code;
    } merge_res_t;

    // Entries with the top bit set select an arrow register by their low two bits
    localparam logic [8:0] CHAR_TABLE [TABLE_DEPTH] = '{
        9'h040, 9'h041, 9'h042, 9'h043, 9'h044, 9'h045, 9'h046, 9'h047, // @ A-G
        9'h048, 9'h049, 9'h04A, 9'h04B, 9'h04C, 9'h04D, 9'h04E, 9'h04F, // H-O
        9'h050, 9'h051, 9'h052, 9'h053, 9'h054, 9'h055, 9'h056, 9'h057, // P-W
        9'h058, 9'h059, 9'h05A, 9'h05A, 9'h05A, 9'h05A, 9'h05A, 9'h05A, // X Y Z..
        9'h030, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037, // 0-7
        9'h038, 9'h039, 9'h03A, 9'h03B, 9'h02C, 9'h02D, 9'h02E, 9'h02F, // 8 9 : ; , - . /
        9'h00D, 9'h008, 9'h05A, 9'h100, 9'h101, 9'h102, 9'h103, 9'h020  // CR BS Z arrows sp
    };

    function automatic logic [CODE_W-1:0] char_code(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] column,
        input arrow_codes_t     arrows
    );
        logic [ROW_W+COL_W-1:0] idx;
        logic [8:0]             entry;
        logic [CODE_W-1:0]      code;
        idx   = {row, column};
        entry = (idx < (ROW_W+COL_W)'(TABLE_DEPTH)) ? CHAR_TABLE[idx] : 9'h000;
        if (entry[8])
            code = arrows[entry[1:0]];
        else
            code = entry[CODE_W-1:0];
        return code;
    endfunction

endpackage

// ----- hdl/kmpd_lane.sv -----
// One row lane: change detect, new press detect and top changed column.
module kmpd_lane (
    input  kmpd_pkg::row_bits_t row_bits,
    input  kmpd_pkg::row_bits_t prev_bits,
    output kmpd_pkg::lane_res_t res
);
    import kmpd_pkg::*;

    row_bits_t        diff;
    logic [COL_W-1:0] top;

    assign diff = row_bits ^ prev_bits;

    // Highest changed bit wins, even if it is a release
    always_comb
    begin
        top = '0;
        for (int k = 0; k < NUM_COLS; k++)
        begin
            if (diff[k])
                top = COL_W'(k);
        end
    end

    assign res.changed = |diff;
    assign res.pressed = |(row_bits & diff);
    assign res.column  = top;

endmodule

// ----- hdl/kmpd_merge.sv -----
// Merge of the row lanes: priority pick, hold resolution and character decode.
module kmpd_merge (
    input  kmpd_pkg::lane_res_t                    lanes [kmpd_pkg::NUM_ROWS],
    input  logic                                   hold_in,
    input  logic [kmpd_pkg::ROW_W-1:0]             row_in,
    input  logic [kmpd_pkg::COL_W-1:0]             column_in,
    input  kmpd_pkg::arrow_codes_t                 arrows,
    input  logic [kmpd_pkg::CODE_W-1:0]            held_code,
    output kmpd_pkg::merge_res_t                   res
);
    import kmpd_pkg::*;

    logic              hit;
    logic              any_change;
    logic              later_change;
    logic [ROW_W-1:0]  hit_row;
    logic              hold_mid;
    logic [CODE_W-1:0] lookup_code;

    always_comb
    begin
        hit        = 1'b0;
        any_change = 1'b0;
        hit_row    = '0;
        // Lowest pressed row has priority
        for (int i = NUM_ROWS - 1; i >= 0; i--)
        begin
            if (lanes[i].pressed)
            begin
                hit     = 1'b1;
                hit_row = ROW_W'(i);
            end
            if (lanes[i].changed)
                any_change = 1'b1;
        end
    end

    // A changing row after the hit row drops the hold again
    always_comb
    begin
        later_change = 1'b0;
        for (int j = 0; j < NUM_ROWS; j++)
        begin
            if (lanes[j].changed && (ROW_W'(j) > hit_row))
                later_change = 1'b1;
        end
    end

    always_comb
    begin
        res.hit    = hit;
        res.row    = hit ? hit_row : row_in;
        res.column = hit ? lanes[hit_row].column : column_in;
        if (hit)
            hold_mid = !later_change;
        else
            hold_mid = any_change ? 1'b0 : hold_in;

        lookup_code = char_code(res.row, res.column, arrows);
        res.hold    = hold_mid;
        res.code    = '0;
        if (hold_mid && (res.row != ROW_MODIFIER))
        begin
            if (!hit && (held_code != lookup_code))
                res.hold = 1'b0;
            else
                res.code = lookup_code;
        end
    end

endmodule

// ----- hdl/key_matrix_press_decoder.sv -----
// Top level of the key matrix press decoder: lanes, merge, scan state and output skid.
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   scan in   | in_valid, in_stall, row0..7_bits, held_code | in
//   result    | out_valid, out_stall, key_code, new_press | out
//   config    | cfg_write_en, cfg_index, cfg_data         | in
//
// One scan is taken per cycle while in_stall is low; its result goes to the output
// register, or to the skid register when the output is stalled. The eight row lanes
// and the merge are combinational, since the next scan compares against the rows
// stored by this one. Reset clears the stored rows and hold flag, sets the active
// row to seven and loads the default arrow codes. A stalled result parks in a
// one-entry skid register; the input stalls only while that skid entry is full.
module key_matrix_press_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [7:0]                            row0_bits,
    input  logic [7:0]                            row1_bits,
    input  logic [7:0]                            row2_bits,
    input  logic [7:0]                            row3_bits,
    input  logic [7:0]                            row4_bits,
    input  logic [7:0]                            row5_bits,
    input  logic [7:0]                            row6_bits,
    input  logic [7:0]                            row7_bits,
    input  logic [kmpd_pkg::CODE_W-1:0]           held_code,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [kmpd_pkg::CODE_W-1:0]           key_code,
    output logic                                  new_press,
    input  logic                                  cfg_write_en,
    input  logic [kmpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [kmpd_pkg::CODE_W-1:0]           cfg_data
);
    import kmpd_pkg::*;

    row_bits_t         rows      [NUM_ROWS];
    row_bits_t         prev_reg  [NUM_ROWS];
    lane_res_t         lane_res  [NUM_ROWS];
    merge_res_t        merged;
    arrow_codes_t      arrow_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  column_reg;
    logic              hold_reg;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic              out_press_reg;
    logic              skid_valid_reg;
    logic [CODE_W-1:0] skid_code_reg;
    logic              skid_press_reg;

    logic              accept;
    logic              out_free;

    assign rows[0] = row0_bits;
    assign rows[1] = row1_bits;
    assign rows[2] = row2_bits;
    assign rows[3] = row3_bits;
    assign rows[4] = row4_bits;
    assign rows[5] = row5_bits;
    assign rows[6] = row6_bits;
    assign rows[7] = row7_bits;

    genvar g;
    generate
        for (g = 0; g < NUM_ROWS; g++)
        begin : g_lane
            kmpd_lane u_lane (
                .row_bits  (rows[g]),
                .prev_bits (prev_reg[g]),
                .res       (lane_res[g])
            );
        end
    endgenerate

    kmpd_merge u_merge (
        .lanes     (lane_res),
        .hold_in   (hold_reg),
        .row_in    (row_reg),
        .column_in (column_reg),
        .arrows    (arrow_reg),
        .held_code (held_code),
        .res       (merged)
    );

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrow_reg[ARROW_UP]    <= ARROW_UP_RESET;
            arrow_reg[ARROW_DOWN]  <= ARROW_DOWN_RESET;
            arrow_reg[ARROW_LEFT]  <= ARROW_LEFT_RESET;
            arrow_reg[ARROW_RIGHT] <= ARROW_RIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ARROW_UP:    arrow_reg[ARROW_UP]    <= cfg_data;
                REG_ARROW_DOWN:  arrow_reg[ARROW_DOWN]  <= cfg_data;
                REG_ARROW_LEFT:  arrow_reg[ARROW_LEFT]  <= cfg_data;
                REG_ARROW_RIGHT: arrow_reg[ARROW_RIGHT] <= cfg_data;
                default:         ; // drop writes to unused indexes
            endcase
        end
    end

    // Scan state advances on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
                prev_reg[i] <= '0;
            row_reg    <= ROW_MODIFIER;
            column_reg <= '0;
            hold_reg   <= 1'b0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_ROWS; i++)
                prev_reg[i] <= rows[i];
            row_reg    <= merged.row;
            column_reg <= merged.column;
            hold_reg   <= merged.hold;
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_code_reg  <= skid_code_reg;
                out_press_reg <= skid_press_reg;
            end
            else if (accept)
            begin
                out_code_reg  <= merged.code;
                out_press_reg <= merged.hit;
            end
        end
        else if (accept)
        begin
            skid_code_reg  <= merged.code;
            skid_press_reg <= merged.hit;
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = out_code_reg;
    assign new_press = out_press_reg;

endmodule

// ----- hdl/kmpd_checker.sv -----
// Port-level checks for the key matrix press decoder, bound to the top level.
module kmpd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [kmpd_pkg::CODE_W-1:0]       key_code,
    input logic                              new_press
);
    import kmpd_pkg::*;

    // Every input transfer leaves a result pending on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("input transfer without a pending result");

    // The input only stalls while a result is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // Skid fills only behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall raised without output back-pressure");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(key_code) && $stable(new_press)))
        else $error("stalled result changed");

endmodule

bind key_matrix_press_decoder kmpd_checker u_kmpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_code  (key_code),
    .new_press (new_press)
);
